[hdl/chord_symbol_to_midi_notes_macros.svh]
// Assertion macros for the chord symbol to MIDI notes block.
// Used by csm_queue and csm_back; expects clk and rst_n in scope.
`ifndef CHORD_SYMBOL_TO_MIDI_NOTES_MACROS_SVH
`define CHORD_SYMBOL_TO_MIDI_NOTES_MACROS_SVH

// same-cycle implication
`define CSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/csm_pkg.sv]
// Shared types, the quality table and constants for the chord symbol block.
// No dependencies.
package csm_pkg;

  localparam int QUAL_COUNT = 27;
  localparam int Q_DEPTH    = 2;
  localparam int PADDR_W    = 3;
  localparam int NOTE_SLOTS = 7;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_symbol;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [3:0] root_class;
    logic       has_bass;
    logic [3:0] bass_class;
    logic [4:0] quality_code;
    logic       note_present;
    logic [6:0] midi_note;
    logic       run_last;
  } out_item_t;

  // one parsed symbol handed from front to back
  typedef struct packed {
    logic       err;
    logic [3:0] root;
    logic       has_bass;
    logic [3:0] bass;
    logic [4:0] qcode;
  } job_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

  // text: first char in [31:24]; iv: first interval in [29:25]
  typedef struct packed {
    logic [2:0]      len;
    logic [31:0]     text;
    logic [2:0]      count;
    logic [5:0][4:0] iv;
  } qual_t;

  localparam qual_t QUAL_TABLE [QUAL_COUNT] = '{
    '{3'd4, "maj9",          3'd5, {5'd0, 5'd4, 5'd7, 5'd11, 5'd14, 5'd0}},
    '{3'd4, "m7b5",          3'd4, {5'd0, 5'd3, 5'd6, 5'd10, 5'd0, 5'd0}},
    '{3'd4, "dim7",          3'd4, {5'd0, 5'd3, 5'd6, 5'd9, 5'd0, 5'd0}},
    '{3'd4, "add9",          3'd4, {5'd0, 5'd4, 5'd7, 5'd14, 5'd0, 5'd0}},
    '{3'd4, "maj7",          3'd4, {5'd0, 5'd4, 5'd7, 5'd11, 5'd0, 5'd0}},
    '{3'd4, "sus2",          3'd3, {5'd0, 5'd2, 5'd7, 5'd0, 5'd0, 5'd0}},
    '{3'd4, "sus4",          3'd3, {5'd0, 5'd5, 5'd7, 5'd0, 5'd0, 5'd0}},
    '{3'd4, "min7",          3'd3, {5'd0, 5'd3, 5'd10, 5'd0, 5'd0, 5'd0}},
    '{3'd3, {"dim", 8'd0},   3'd3, {5'd0, 5'd3, 5'd6, 5'd0, 5'd0, 5'd0}},
    '{3'd3, {"aug", 8'd0},   3'd3, {5'd0, 5'd4, 5'd8, 5'd0, 5'd0, 5'd0}},
    '{3'd3, {"maj", 8'd0},   3'd3, {5'd0, 5'd4, 5'd7, 5'd0, 5'd0, 5'd0}},
    '{3'd3, {"min", 8'd0},   3'd3, {5'd0, 5'd3, 5'd7, 5'd0, 5'd0, 5'd0}},
    '{3'd3, {"sus", 8'd0},   3'd3, {5'd0, 5'd5, 5'd7, 5'd0, 5'd0, 5'd0}},
    '{3'd2, {"M7", 16'd0},   3'd4, {5'd0, 5'd4, 5'd7, 5'd11, 5'd0, 5'd0}},
    '{3'd2, {"m9", 16'd0},   3'd5, {5'd0, 5'd3, 5'd7, 5'd10, 5'd14, 5'd0}},
    '{3'd2, {"m7", 16'd0},   3'd4, {5'd0, 5'd3, 5'd7, 5'd10, 5'd0, 5'd0}},
    '{3'd2, {"m6", 16'd0},   3'd4, {5'd0, 5'd3, 5'd7, 5'd9, 5'd0, 5'd0}},
    '{3'd2, {"11", 16'd0},   3'd6, {5'd0, 5'd4, 5'd7, 5'd10, 5'd14, 5'd17}},
    '{3'd2, {"13", 16'd0},   3'd6, {5'd0, 5'd4, 5'd7, 5'd10, 5'd14, 5'd21}},
    '{3'd1, {"m", 24'd0},    3'd3, {5'd0, 5'd3, 5'd7, 5'd0, 5'd0, 5'd0}},
    '{3'd1, {"M", 24'd0},    3'd3, {5'd0, 5'd4, 5'd7, 5'd0, 5'd0, 5'd0}},
    '{3'd1, {"-", 24'd0},    3'd3, {5'd0, 5'd3, 5'd7, 5'd0, 5'd0, 5'd0}},
    '{3'd1, {"+", 24'd0},    3'd3, {5'd0, 5'd4, 5'd8, 5'd0, 5'd0, 5'd0}},
    '{3'd1, {"9", 24'd0},    3'd5, {5'd0, 5'd4, 5'd7, 5'd10, 5'd14, 5'd0}},
    '{3'd1, {"7", 24'd0},    3'd4, {5'd0, 5'd4, 5'd7, 5'd10, 5'd0, 5'd0}},
    '{3'd1, {"6", 24'd0},    3'd4, {5'd0, 5'd4, 5'd7, 5'd9, 5'd0, 5'd0}},
    '{3'd0, 32'd0,           3'd3, {5'd0, 5'd4, 5'd7, 5'd0, 5'd0, 5'd0}}
  };

  function automatic qual_t qual_lookup(input logic [4:0] q);
    qual_t ent;
    ent = '0;
    if (q < 5'(QUAL_COUNT)) begin
      ent = QUAL_TABLE[q];
    end
    return ent;
  endfunction

endpackage

[hdl/csm_front.sv]
// Front end: takes one character per cycle unless stalled, tracks parse state, and on
// the end-of-symbol item matches the quality suffix and pushes a job. Uses csm_pkg.
module csm_front #(
  parameter int SUFFIX_MAX_CHARS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  csm_pkg::in_item_t in_data,
  output logic              q_push,
  output csm_pkg::job_t     q_data,
  input  csm_pkg::q_stat_t  q_stat
);

  localparam int LEN_W = $clog2(SUFFIX_MAX_CHARS + 1);
  localparam int IDX_W = $clog2(SUFFIX_MAX_CHARS);

  localparam logic [2:0] PH_LEAD        = 3'd0;
  localparam logic [2:0] PH_AFTER_ROOT  = 3'd1;
  localparam logic [2:0] PH_SUFFIX      = 3'd2;
  localparam logic [2:0] PH_BASS_LETTER = 3'd3;
  localparam logic [2:0] PH_BASS_ACC    = 3'd4;
  localparam logic [2:0] PH_BASS_DONE   = 3'd5;
  localparam logic [2:0] PH_ERR         = 3'd6;

  logic [2:0]       ph_r, ph_nxt;
  logic [3:0]       root_r, root_nxt;
  logic [3:0]       bass_r, bass_nxt;
  logic [7:0]       sbuf_r [SUFFIX_MAX_CHARS];
  logic [7:0]       sbuf_nxt [SUFFIX_MAX_CHARS];
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ts_r, ts_nxt;

  logic       accept;
  logic       ws;
  logic       is_flat;
  logic [4:0] lc;
  logic       found;
  logic [4:0] qsel;
  logic       hit;
  logic       ok;
  logic       bass_phase;
  csm_pkg::qual_t ent;

  // {valid, pitch class}
  function automatic logic [4:0] letter_class(input logic [7:0] c);
    logic [7:0] uc;
    logic [4:0] res;
    uc = (c >= "a" && c <= "g") ? c - 8'd32 : c;
    unique case (uc)
      "A":     res = {1'b1, 4'd9};
      "B":     res = {1'b1, 4'd11};
      "C":     res = {1'b1, 4'd0};
      "D":     res = {1'b1, 4'd2};
      "E":     res = {1'b1, 4'd4};
      "F":     res = {1'b1, 4'd5};
      "G":     res = {1'b1, 4'd7};
      default: res = 5'd0;
    endcase
    return res;
  endfunction

  function automatic logic [3:0] pc_up(input logic [3:0] p);
    return (p == 4'd11) ? 4'd0 : p + 4'd1;
  endfunction

  function automatic logic [3:0] pc_down(input logic [3:0] p);
    return (p == 4'd0) ? 4'd11 : p - 4'd1;
  endfunction

  assign in_stall = q_stat.full & in_data.end_of_symbol;
  assign accept   = in_valid & ~in_stall;
  assign q_push   = accept & in_data.end_of_symbol;

  assign ws = (in_data.char_code == 8'h20) || (in_data.char_code == 8'h09) ||
              (in_data.char_code == 8'h0D) || (in_data.char_code == 8'h0A);
  assign is_flat = (in_data.char_code == "b") || (in_data.char_code == "B");
  assign lc = letter_class(in_data.char_code);

  always_comb begin
    ph_nxt   = ph_r;
    root_nxt = root_r;
    bass_nxt = bass_r;
    sbuf_nxt = sbuf_r;
    len_nxt  = len_r;
    ts_nxt   = ts_r;
    if (ph_r == PH_ERR) begin
      ph_nxt = PH_ERR;
    end else if (ph_r == PH_LEAD) begin
      if (!ws) begin
        if (lc[4]) begin
          root_nxt = lc[3:0];
          ph_nxt   = PH_AFTER_ROOT;
        end else begin
          ph_nxt = PH_ERR;
        end
      end
    end else if (ws) begin
      ts_nxt = 1'b1;
    end else if (ts_r) begin
      ph_nxt = PH_ERR;
    end else begin
      unique case (ph_r)
        PH_AFTER_ROOT, PH_SUFFIX: begin
          if (ph_r == PH_AFTER_ROOT && in_data.char_code == "#") begin
            root_nxt = pc_up(root_r);
            ph_nxt   = PH_SUFFIX;
          end else if (ph_r == PH_AFTER_ROOT && is_flat) begin
            root_nxt = pc_down(root_r);
            ph_nxt   = PH_SUFFIX;
          end else if (in_data.char_code == "/") begin
            ph_nxt = PH_BASS_LETTER;
          end else if (len_r == LEN_W'(SUFFIX_MAX_CHARS)) begin
            ph_nxt = PH_ERR;
          end else begin
            sbuf_nxt[len_r[IDX_W-1:0]] = in_data.char_code;
            len_nxt = len_r + 1'b1;
            ph_nxt  = PH_SUFFIX;
          end
        end
        PH_BASS_LETTER: begin
          if (lc[4]) begin
            bass_nxt = lc[3:0];
            ph_nxt   = PH_BASS_ACC;
          end else begin
            ph_nxt = PH_ERR;
          end
        end
        PH_BASS_ACC: begin
          if (in_data.char_code == "#") begin
            bass_nxt = pc_up(bass_r);
            ph_nxt   = PH_BASS_DONE;
          end else if (is_flat) begin
            bass_nxt = pc_down(bass_r);
            ph_nxt   = PH_BASS_DONE;
          end else begin
            ph_nxt = PH_ERR;
          end
        end
        default: ph_nxt = PH_ERR;
      endcase
    end
  end

  // lowest matching table index wins
  always_comb begin
    found = 1'b0;
    qsel  = 5'd0;
    ent   = '0;
    hit   = 1'b0;
    for (int q = csm_pkg::QUAL_COUNT - 1; q >= 0; q--) begin
      ent = csm_pkg::QUAL_TABLE[q];
      hit = (len_nxt == LEN_W'(ent.len));
      for (int i = 0; i < 4; i++) begin
        if (i < ent.len) begin
          hit = hit & (sbuf_nxt[i] == ent.text[31-8*i -: 8]);
        end
      end
      if (hit) begin
        found = 1'b1;
        qsel  = 5'(q);
      end
    end
  end

  assign bass_phase = (ph_nxt == PH_BASS_ACC) || (ph_nxt == PH_BASS_DONE);
  assign ok = found && ((ph_nxt == PH_AFTER_ROOT) || (ph_nxt == PH_SUFFIX) || bass_phase);

  always_comb begin
    q_data          = '0;
    q_data.err      = ~ok;
    q_data.root     = ok ? root_nxt : 4'd0;
    q_data.has_bass = ok && bass_phase && (bass_nxt != root_nxt);
    q_data.bass     = q_data.has_bass ? bass_nxt : 4'd0;
    q_data.qcode    = ok ? qsel : 5'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_LEAD;
      root_r <= 4'd0;
      bass_r <= 4'd0;
      len_r  <= '0;
      ts_r   <= 1'b0;
    end else if (accept) begin
      if (in_data.end_of_symbol) begin
        ph_r   <= PH_LEAD;
        root_r <= 4'd0;
        bass_r <= 4'd0;
        len_r  <= '0;
        ts_r   <= 1'b0;
      end else begin
        ph_r   <= ph_nxt;
        root_r <= root_nxt;
        bass_r <= bass_nxt;
        len_r  <= len_nxt;
        ts_r   <= ts_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_data.end_of_symbol) begin
      sbuf_r <= sbuf_nxt;
    end
  end

endmodule

[hdl/csm_queue.sv]
// Two-entry job queue between the parse front end and the note back end.
// Uses csm_pkg and the assertion macros header.
`include "chord_symbol_to_midi_notes_macros.svh"

module csm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  csm_pkg::job_t    push_data,
  input  logic             pop,
  output csm_pkg::job_t    head,
  output csm_pkg::q_stat_t stat
);

  localparam int DEPTH = csm_pkg::Q_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  csm_pkg::job_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head       = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.avail = (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  `CSM_ASSERT_IMP(a_no_overflow, push, !stat.full, "push into full job queue")
  `CSM_ASSERT_IMP(a_no_underflow, pop, stat.avail, "pop from empty job queue")
  `CSM_ASSERT_NXT(a_count_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "queue count off")

endmodule

[hdl/csm_back.sv]
// Back end: turns a job into its run of MIDI notes through an output register,
// one result per cycle when not stalled. Uses csm_pkg and the assertion macros header.
`include "chord_symbol_to_midi_notes_macros.svh"

module csm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [4:0]  octave,
  input  csm_pkg::job_t      q_head,
  input  csm_pkg::q_stat_t   q_stat,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output csm_pkg::out_item_t out_data
);

  localparam int SLOTS = csm_pkg::NOTE_SLOTS;
  localparam int SEL_W = $clog2(SLOTS);

  logic               cur_valid_r, cur_valid_nxt;
  csm_pkg::job_t      cur_job_r;
  logic [SLOTS-1:0]   cur_mask_r, cur_mask_nxt;
  logic               cur_empty_r;
  logic [6:0]         cur_note_r [SLOTS];
  logic               out_valid_r, out_valid_nxt;
  csm_pkg::out_item_t out_data_r, res;

  csm_pkg::qual_t   ent;
  logic [9:0]       oct_x, base, root_n;
  logic [9:0]       cand [SLOTS];
  logic [SLOTS-1:0] new_mask;
  logic [SEL_W-1:0] sel;
  logic [SLOTS-1:0] rest;
  logic             last, out_free, emit, done, load;

  // candidate notes: slot 0 is the bass, slots 1.. are root plus interval
  always_comb begin
    ent    = csm_pkg::qual_lookup(q_head.qcode);
    oct_x  = {{5{octave[4]}}, octave};
    base   = (oct_x << 3) + (oct_x << 2);
    root_n = base + 10'd12 + {6'd0, q_head.root};
    cand[0]     = base + {6'd0, q_head.bass};
    new_mask[0] = q_head.has_bass && (cand[0][9:7] == 3'd0);
    for (int k = 1; k < SLOTS; k++) begin
      cand[k]     = root_n + {5'd0, ent.iv[6-k]};
      new_mask[k] = (k <= ent.count) && (cand[k][9:7] == 3'd0);
    end
    if (q_head.err) begin
      new_mask = '0;
    end
  end

  always_comb begin
    sel = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (cur_mask_r[k]) begin
        sel = SEL_W'(k);
      end
    end
  end

  assign rest     = cur_mask_r & (cur_mask_r - 1'b1);
  assign last     = cur_job_r.err || cur_empty_r || (rest == '0);
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = cur_valid_r && out_free;
  assign done     = emit && last;
  assign load     = q_stat.avail && (!cur_valid_r || done);
  assign q_pop    = load;

  always_comb begin
    res = '0;
    if (cur_job_r.err) begin
      res.status   = 1'b1;
      res.run_last = 1'b1;
    end else begin
      res.root_class   = cur_job_r.root;
      res.has_bass     = cur_job_r.has_bass;
      res.bass_class   = cur_job_r.bass;
      res.quality_code = cur_job_r.qcode;
      res.note_present = !cur_empty_r;
      res.midi_note    = cur_empty_r ? 7'd0 : cur_note_r[sel];
      res.run_last     = last;
    end
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_mask_nxt  = cur_mask_r;
    if (load) begin
      cur_valid_nxt = 1'b1;
      cur_mask_nxt  = new_mask;
    end else if (done) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      cur_mask_nxt = rest;
    end
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cur_mask_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      cur_mask_r  <= cur_mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_job_r   <= q_head;
      cur_empty_r <= (new_mask == '0);
      for (int k = 0; k < SLOTS; k++) begin
        cur_note_r[k] <= cand[k][6:0];
      end
    end
    if (emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CSM_ASSERT_IMP(a_err_no_notes, cur_valid_r && cur_job_r.err, cur_mask_r == '0, "error job has notes")
  `CSM_ASSERT_NXT(a_run_continues, emit && !last, cur_valid_r, "run dropped before its last note")
  `CSM_ASSERT_IMP(a_status_ends_run, out_valid_r && out_data_r.status, out_data_r.run_last, "status result not last")

endmodule

[hdl/chord_symbol_to_midi_notes.sv]
// Chord symbol to MIDI notes, top level: config register, front end, job queue, back end.
// Depends on csm_pkg, csm_front, csm_queue and csm_back.
//
// Characters are taken one per cycle. An item without the end mark never
// stalls; the end-of-symbol item pushes a parsed job into a two-entry queue
// and stalls only while that queue is full. The back end emits one result
// per cycle from its output register unless out_stall holds it: up to seven
// notes per symbol (bass plus up to six chord tones), or a single status or
// empty-run result. The octave register sits at byte address 0, mirrored at
// every address with the top paddr bit clear, and is read by the back end
// when a job is taken from the queue.
module chord_symbol_to_midi_notes #(
  parameter int SUFFIX_MAX_CHARS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  csm_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output csm_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [csm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic signed [4:0] octave_r;
  logic              cfg_wr;
  logic              q_push, q_pop;
  csm_pkg::job_t     q_in, q_head;
  csm_pkg::q_stat_t  q_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[csm_pkg::PADDR_W-1] == 1'b0);
  assign prdata = (paddr[csm_pkg::PADDR_W-1] == 1'b0) ? {27'd0, octave_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_r <= 5'sd4;
    end else if (cfg_wr) begin
      octave_r <= pwdata[4:0];
    end
  end

  csm_front #(
    .SUFFIX_MAX_CHARS(SUFFIX_MAX_CHARS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_stat   (q_stat)
  );

  csm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  csm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .octave    (octave_r),
    .q_head    (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[dv/chord_symbol_to_midi_notes_checker.sv]
// Checker for the chord symbol to MIDI notes block: mirrors the parser and note
// expansion, keeps the octave register from the config bus, and compares results.
// Depends on csm_pkg for the channel item types.
module chord_symbol_to_midi_notes_checker #(
  parameter logic [csm_pkg::PADDR_W-1:0] OCTAVE_ADDR = '0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  csm_pkg::in_item_t           in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  csm_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [csm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          mismatches,
  output int                          notes_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SFX_MAX = 4;
  localparam int CHORD_KINDS = 27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SHARP = "#";
  localparam logic [7:0] CH_SLASH = "/";

  typedef enum logic [2:0] {
    SYM_LEAD, SYM_ROOT, SYM_SUFFIX, SYM_BASS_START, SYM_BASS_ACC, SYM_BASS_END, SYM_BAD
  } sym_phase_e;

  string sfx_text [CHORD_KINDS] = '{
    "maj9", "m7b5", "dim7", "add9", "maj7", "sus2", "sus4", "min7",
    "dim", "aug", "maj", "min", "sus",
    "M7", "m9", "m7", "m6", "11", "13",
    "m", "M", "-", "+", "9", "7", "6", ""
  };
  int chord_cnt [CHORD_KINDS] = '{
    5, 4, 4, 4, 4, 3, 3, 3, 3, 3, 3, 3, 3, 4, 5, 4, 4, 6, 6, 3, 3, 3, 3, 5, 4, 4, 3
  };
  int chord_ivl [CHORD_KINDS][6] = '{
    '{0, 4, 7, 11, 14, 0}, '{0, 3, 6, 10, 0, 0}, '{0, 3, 6, 9, 0, 0},
    '{0, 4, 7, 14, 0, 0},  '{0, 4, 7, 11, 0, 0}, '{0, 2, 7, 0, 0, 0},
    '{0, 5, 7, 0, 0, 0},   '{0, 3, 10, 0, 0, 0}, '{0, 3, 6, 0, 0, 0},
    '{0, 4, 8, 0, 0, 0},   '{0, 4, 7, 0, 0, 0},  '{0, 3, 7, 0, 0, 0},
    '{0, 5, 7, 0, 0, 0},   '{0, 4, 7, 11, 0, 0}, '{0, 3, 7, 10, 14, 0},
    '{0, 3, 7, 10, 0, 0},  '{0, 3, 7, 9, 0, 0},  '{0, 4, 7, 10, 14, 17},
    '{0, 4, 7, 10, 14, 21}, '{0, 3, 7, 0, 0, 0}, '{0, 4, 7, 0, 0, 0},
    '{0, 3, 7, 0, 0, 0},   '{0, 4, 8, 0, 0, 0},  '{0, 4, 7, 10, 14, 0},
    '{0, 4, 7, 10, 0, 0},  '{0, 4, 7, 9, 0, 0},  '{0, 4, 7, 0, 0, 0}
  };

  logic signed [4:0]  octave;
  sym_phase_e         phase;
  logic [3:0]         root_pc;
  logic [3:0]         bass_pc;
  logic [7:0]         sfx_buf [SFX_MAX];
  int                 sfx_len;
  logic               tail_ws;
  csm_pkg::out_item_t notes_q [$];

  task automatic report(input string msg);
    mismatches++;
    $display("checker: %s at %0t", msg, $realtime);
  endtask

  task automatic clear_symbol();
    phase = SYM_LEAD;
    root_pc = '0;
    bass_pc = '0;
    for (int i = 0; i < SFX_MAX; i++) sfx_buf[i] = '0;
    sfx_len = 0;
    tail_ws = 1'b0;
  endtask

  function automatic int letter_pc(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (u >= "a" && u <= "g") u = u - 8'd32;
    case (u)
      "A": return 9;
      "B": return 11;
      "C": return 0;
      "D": return 2;
      "E": return 4;
      "F": return 5;
      "G": return 7;
      default: return -1;
    endcase
  endfunction

  function automatic logic is_flat(input logic [7:0] c);
    return c == "b" || c == "B";
  endfunction

  task automatic add_sfx(input logic [7:0] c);
    if (sfx_len >= SFX_MAX) begin
      phase = SYM_BAD;
      return;
    end
    sfx_buf[sfx_len] = c;
    sfx_len++;
    phase = SYM_SUFFIX;
  endtask

  task automatic take_char(input logic [7:0] c);
    logic ws;
    int pc;
    ws = c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    if (phase == SYM_BAD) return;
    if (phase == SYM_LEAD) begin
      if (ws) return;
      pc = letter_pc(c);
      if (pc < 0) begin
        phase = SYM_BAD;
      end else begin
        root_pc = 4'(pc);
        phase = SYM_ROOT;
      end
      return;
    end
    if (ws) begin
      tail_ws = 1'b1;
      return;
    end
    if (tail_ws) begin
      phase = SYM_BAD;
      return;
    end
    case (phase)
      SYM_ROOT: begin
        if (c == CH_SHARP) begin
          root_pc = 4'((int'(root_pc) + 1) % 12);
          phase = SYM_SUFFIX;
        end else if (is_flat(c)) begin
          root_pc = 4'((int'(root_pc) + 11) % 12);
          phase = SYM_SUFFIX;
        end else if (c == CH_SLASH) begin
          phase = SYM_BASS_START;
        end else begin
          add_sfx(c);
        end
      end
      SYM_SUFFIX: begin
        if (c == CH_SLASH) phase = SYM_BASS_START;
        else add_sfx(c);
      end
      SYM_BASS_START: begin
        pc = letter_pc(c);
        if (pc < 0) begin
          phase = SYM_BAD;
        end else begin
          bass_pc = 4'(pc);
          phase = SYM_BASS_ACC;
        end
      end
      SYM_BASS_ACC: begin
        if (c == CH_SHARP) begin
          bass_pc = 4'((int'(bass_pc) + 1) % 12);
          phase = SYM_BASS_END;
        end else if (is_flat(c)) begin
          bass_pc = 4'((int'(bass_pc) + 11) % 12);
          phase = SYM_BASS_END;
        end else begin
          phase = SYM_BAD;
        end
      end
      default: phase = SYM_BAD;
    endcase
  endtask

  function automatic int match_quality();
    logic same;
    for (int q = 0; q < CHORD_KINDS; q++) begin
      if (sfx_text[q].len() != sfx_len) continue;
      same = 1'b1;
      for (int i = 0; i < sfx_len; i++) begin
        if (sfx_buf[i] != 8'(sfx_text[q][i])) same = 1'b0;
      end
      if (same) return q;
    end
    return -1;
  endfunction

  // end of symbol: expand into the expected note run
  task automatic close_symbol();
    int q;
    int octv;
    int base;
    int v;
    int n;
    int runs;
    int notes [7];
    logic hb;
    csm_pkg::out_item_t r;
    q = -1;
    if (phase == SYM_ROOT || phase == SYM_SUFFIX || phase == SYM_BASS_ACC ||
        phase == SYM_BASS_END) begin
      q = match_quality();
    end
    if (q < 0) begin
      r = '0;
      r.status = 1'b1;
      r.run_last = 1'b1;
      notes_q = {notes_q, r};
    end else begin
      hb = (phase == SYM_BASS_ACC || phase == SYM_BASS_END) && bass_pc != root_pc;
      octv = int'(octave);
      base = (octv + 1) * 12 + int'(root_pc);
      n = 0;
      if (hb) begin
        v = octv * 12 + int'(bass_pc);
        if (v >= 0 && v <= 127) begin
          notes[n] = v;
          n++;
        end
      end
      for (int k = 0; k < chord_cnt[q]; k++) begin
        v = base + chord_ivl[q][k];
        if (v >= 0 && v <= 127) begin
          notes[n] = v;
          n++;
        end
      end
      runs = n > 0 ? n : 1;
      for (int k = 0; k < runs; k++) begin
        r = '0;
        r.root_class = root_pc;
        r.has_bass = hb;
        r.bass_class = hb ? bass_pc : 4'd0;
        r.quality_code = 5'(q);
        r.note_present = n > 0;
        r.midi_note = n > 0 ? 7'(notes[k]) : 7'd0;
        r.run_last = k == runs - 1;
        notes_q = {notes_q, r};
      end
    end
    clear_symbol();
  endtask

  task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  task automatic check_note(input csm_pkg::out_item_t got);
    csm_pkg::out_item_t want;
    if (notes_q.size() == 0) begin
      report($sformatf("result with nothing expected: %p", got));
      return;
    end
    want = notes_q.pop_front();
    cmp_field("status", 8'(got.status), 8'(want.status));
    cmp_field("root_class", 8'(got.root_class), 8'(want.root_class));
    cmp_field("has_bass", 8'(got.has_bass), 8'(want.has_bass));
    cmp_field("bass_class", 8'(got.bass_class), 8'(want.bass_class));
    cmp_field("quality_code", 8'(got.quality_code), 8'(want.quality_code));
    cmp_field("note_present", 8'(got.note_present), 8'(want.note_present));
    cmp_field("midi_note", 8'(got.midi_note), 8'(want.midi_note));
    cmp_field("run_last", 8'(got.run_last), 8'(want.run_last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_symbol();
      notes_q.delete();
      octave = 5'sd4;
      mismatches = 0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) check_note(out_data);
      if (in_valid && !in_stall) begin
        take_char(in_data.char_code);
        if (in_data.end_of_symbol) close_symbol();
      end
      if (psel && penable && pwrite && pready && paddr == OCTAVE_ADDR) begin
        octave = pwdata[4:0];
      end
    end
    notes_due = notes_q.size();
  end

endmodule

[dv/chord_symbol_to_midi_notes_tb.sv]
// Testbench top for chord_symbol_to_midi_notes: clock, reset, symbol stimulus,
// octave register writes, result stall pattern and the final verdict.
// Depends on csm_pkg, the block and chord_symbol_to_midi_notes_checker.
module chord_symbol_to_midi_notes_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [csm_pkg::PADDR_W-1:0] OCTAVE_ADDR = '0;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int ITEM_TARGET  = 410;
  localparam int PHASES       = 6;
  localparam int DRAIN_CYCLES = 16;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  csm_pkg::in_item_t           in_data;
  logic                        out_valid;
  logic                        out_stall;
  csm_pkg::out_item_t          out_data;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [csm_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  int   mismatches;
  int   notes_due;
  int   quiet_cycles;
  int   hold_left;
  int   phase_items;
  int   total_items;
  bit   in_idle_en;
  bit   out_idle_en;
  bit   hold_req;
  logic [7:0] sym_chars [$];

  string ws_set = " \t\r\n";
  string chord_sfx [27] = '{
    "maj9", "m7b5", "dim7", "add9", "maj7", "sus2", "sus4", "min7",
    "dim", "aug", "maj", "min", "sus",
    "M7", "m9", "m7", "m6", "11", "13",
    "m", "M", "-", "+", "9", "7", "6", ""
  };
  string directed [22] = '{
    "C", " c#maj9\t", "Bbm7b5", "Gsus4/D", "E/e", "A13", "F#11/C", "Dm7/",
    "C/Gx", "Cmaj9x", "H", "C m", "\r\n", "DB-/F#", "ebdim7/Ab", "Cmj",
    "C#b", "g+ ", "Am9/G ", "Fadd9", "\tBaug", "C6 /E"
  };

  chord_symbol_to_midi_notes i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  chord_symbol_to_midi_notes_checker #(
    .OCTAVE_ADDR (OCTAVE_ADDR)
  ) i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .notes_due  (notes_due)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result side: random stall, or a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= out_idle_en && ($urandom_range(99) < 21);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("chord_symbol_to_midi_notes_tb: errors");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [7:0] c, input logic eos);
    while (in_idle_en && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {c, eos};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    phase_items++;
    total_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(8'(s[i]), i == s.len() - 1);
  endtask

  task automatic send_chars();
    for (int i = 0; i < sym_chars.size(); i++) send_item(sym_chars[i], i == sym_chars.size() - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (notes_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_octave(input logic [4:0] oct);
    logic [31:0] word;
    wait_idle();
    word = $urandom();
    word[4:0] = oct;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= OCTAVE_ADDR;
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic add_char(input logic [7:0] c);
    sym_chars = {sym_chars, c};
  endtask

  task automatic push_note_name();
    logic [7:0] c;
    c = 8'("A") + 8'($urandom_range(6));
    if ($urandom_range(1)) c = c + 8'd32;
    add_char(c);
    case ($urandom_range(3))
      1: add_char("#");
      2: add_char("b");
      3: add_char("B");
      default: ;
    endcase
  endtask

  // mostly well-formed symbols; some with noise, inner gaps or cut short
  task automatic make_symbol();
    int pick;
    int k;
    string sfx;
    sym_chars.delete();
    pick = $urandom_range(99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 4)) add_char(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(2)) add_char(8'(ws_set[$urandom_range(3)]));
    push_note_name();
    if ($urandom_range(99) < 85) begin
      sfx = chord_sfx[$urandom_range(26)];
      for (int i = 0; i < sfx.len(); i++) add_char(8'(sfx[i]));
    end else begin
      repeat ($urandom_range(1, 5)) add_char(8'($urandom_range(33, 126)));
    end
    if ($urandom_range(99) < 30) begin
      add_char("/");
      push_note_name();
    end
    repeat ($urandom_range(2)) add_char(8'(ws_set[$urandom_range(3)]));
    if (pick < 16) begin
      k = $urandom_range(sym_chars.size() - 1);
      case ($urandom_range(2))
        0: sym_chars[k] = 8'($urandom_range(255));
        1: sym_chars.insert(k, 8'(ws_set[$urandom_range(3)]));
        default: if (sym_chars.size() > 1) void'(sym_chars.pop_back());
      endcase
    end
  endtask

  initial begin
    logic [4:0] phase_oct [PHASES];
    logic [4:0] edge_oct [4];
    int quota;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    hold_req = 1'b0;
    quiet_cycles = 0;
    phase_items = 0;
    total_items = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_text(directed[i]);
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b1);

    edge_oct = '{5'h1f, 5'd9, 5'h10, 5'h0f};
    foreach (edge_oct[i]) begin
      set_octave(edge_oct[i]);
      send_text("B13/A#");
      send_text("c/e");
      send_text("Cmaj9/B");
    end

    phase_oct = '{5'd0, 5'd9, 5'h1f, 5'($urandom_range(31)), 5'd4, 5'($urandom_range(31))};
    for (int p = 0; p < PHASES; p++) begin
      set_octave(phase_oct[p]);
      in_idle_en = p != 1;
      out_idle_en = p != 1;
      quota = (ITEM_TARGET - total_items) / (PHASES - p);
      phase_items = 0;
      if (p == 3) begin
        hold_req = 1'b1;
        repeat (24) begin
          sym_chars.delete();
          push_note_name();
          send_chars();
        end
      end
      while (phase_items < quota) begin
        make_symbol();
        send_chars();
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("chord_symbol_to_midi_notes_tb: clean");
    end else begin
      $display("chord_symbol_to_midi_notes_tb: errors");
    end
    $finish;
  end

endmodule

[chord_symbol_to_midi_notes.f]
+incdir+hdl
hdl/csm_pkg.sv
hdl/csm_front.sv
hdl/csm_queue.sv
hdl/csm_back.sv
hdl/chord_symbol_to_midi_notes.sv
dv/chord_symbol_to_midi_notes_checker.sv
dv/chord_symbol_to_midi_notes_tb.sv
